// File: hdl/pect_pkg.sv
// ----------------------------------------------------------------------------
// pect_pkg
// Shared types, widths and helpers for the polygon ear-clip triangulator.
// ----------------------------------------------------------------------------
package pect_pkg;

    localparam int MAX_CORNERS = 32;
    localparam int IDX_W       = $clog2(MAX_CORNERS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int COORD_W     = 16;
    localparam int OPD_W       = COORD_W + 1;
    localparam int PROD_W      = 2 * OPD_W;
    localparam int CROSS_W     = PROD_W + 1;
    localparam int ACC_W       = PROD_W + IDX_W + 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] corner_x;
        logic signed [COORD_W-1:0] corner_y;
        logic signed [COORD_W-1:0] corner_z;
        logic                      last_corner;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0] tri_first;
        logic [IDX_W-1:0] tri_second;
        logic [IDX_W-1:0] tri_third;
        logic             last_triangle;
        logic             fan_fallback;
        logic             corners_dropped;
    } t_out_word;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_corner;

    typedef struct packed {
        logic signed [COORD_W-1:0] u;
        logic signed [COORD_W-1:0] v;
    } t_pt;

    typedef struct packed {
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] second;
        logic [IDX_W-1:0] third;
    } t_tri;

    // projection plane, named by the two kept axes
    typedef enum logic [1:0] {
        PL_YZ,
        PL_ZX,
        PL_XY
    } t_plane;

    function automatic t_pt proj(input t_corner c, input t_plane pl);
        t_pt p;
        unique case (pl)
            PL_YZ: begin
                p.u = c.y;
                p.v = c.z;
            end
            PL_ZX: begin
                p.u = c.z;
                p.v = c.x;
            end
            default: begin
                p.u = c.x;
                p.v = c.y;
            end
        endcase
        return p;
    endfunction

    function automatic logic signed [OPD_W-1:0] sub_w(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        return OPD_W'(a) - OPD_W'(b);
    endfunction

    function automatic logic signed [OPD_W-1:0] add_w(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        return OPD_W'(a) + OPD_W'(b);
    endfunction

    function automatic logic [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] a);
        return a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
    endfunction

endpackage

// File: hdl/pect_ram.sv
// ----------------------------------------------------------------------------
// pect_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pect_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/polygon_ear_clip_triangulator.sv
// ----------------------------------------------------------------------------
// polygon_ear_clip_triangulator
// Stores polygon corners, picks a projection plane and clips ears into
// corner-index triangles.
// ----------------------------------------------------------------------------
// Corners are taken one word at a time; each stored corner after the first
// holds the input while one shared multiplier adds its Newell normal terms,
// and the normal (and with it the signed area of the chosen plane) is
// complete once the closing edge back to the first corner is added.
// Triangulation then runs from three RAMs (corners, next links, triangle
// list) with one read a cycle each: setup writes one next link per corner,
// each ear candidate reads its next link and three corners, and each
// containment probe reads one more corner and tests it against three sides.
// Triangles are buffered, then handed out one word at a time; the next
// polygon's first corner is taken while the final word waits at the output.
module polygon_ear_clip_triangulator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pect_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pect_pkg::t_out_word o_out_word
);

    typedef enum logic [4:0] {
        S_IN, S_WRAP, S_TERM, S_SETUP, S_LINK, S_STEP, S_LD, S_CP, S_CC, S_CN,
        S_TURN, S_PL, S_PQ, S_SIDE, S_NOEAR, S_CLIP, S_FIN, S_FAN0, S_FAN1,
        S_FAN2, S_ORD, S_OLD
    } t_state;

    localparam int IW = pect_pkg::IDX_W;
    localparam int CW = pect_pkg::CNT_W;
    localparam int AW = pect_pkg::ACC_W;
    localparam int PW = pect_pkg::PROD_W;
    localparam int XW = pect_pkg::CROSS_W;
    localparam int TW = $bits(pect_pkg::t_tri);

    t_state r_st, n_st;
    logic [CW-1:0] r_count, n_count, r_rem, n_rem, r_noprog, n_noprog;
    logic r_ovf, n_ovf, r_closing, n_closing, r_wrapped, n_wrapped;
    pect_pkg::t_corner r_first, n_first, r_last, n_last, r_a, n_a, r_b, n_b;
    logic [2:0] r_ph, n_ph;
    logic signed [AW-1:0] r_nx, n_nx, r_ny, n_ny, r_nz, n_nz;
    logic signed [PW-1:0] r_pa, n_pa, r_pb, n_pb;
    pect_pkg::t_plane r_plane, n_plane;
    logic r_ccw, n_ccw, r_fan, n_fan, r_neg, n_neg, r_pos, n_pos;
    logic [IW-1:0] r_i, n_i, r_cur, n_cur, r_pv, n_pv, r_nv, n_nv;
    logic [IW-1:0] r_ntri, n_ntri, r_probe, n_probe, r_fb, n_fb, r_k, n_k;
    pect_pkg::t_pt r_pp, n_pp, r_pc, n_pc, r_pn, n_pn, r_pq, n_pq;
    logic [1:0] r_sd, n_sd;
    logic r_ovalid, n_ovalid;
    pect_pkg::t_out_word r_oword, n_oword;

    // memory ports
    logic c_we, c_re, l_we, l_re, t_we, t_re;
    logic [IW-1:0] c_waddr, c_raddr, l_waddr, l_raddr, l_wdata, l_rdata, t_waddr, t_raddr;
    pect_pkg::t_corner c_wdata, c_rdata;
    pect_pkg::t_tri t_wdata, t_rdata;

    logic signed [pect_pkg::OPD_W-1:0] ma, mb;
    logic signed [PW-1:0] prod;
    logic signed [XW-1:0] xprod;
    pect_pkg::t_pt c_proj, sa, sb;
    pect_pkg::t_corner in_c;
    logic [AW-1:0] ax, ay, az;
    logic neg_now, pos_now, ear, last_link, last_out;

    pect_ram #(.WIDTH($bits(pect_pkg::t_corner)), .DEPTH(pect_pkg::MAX_CORNERS)) u_corner (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_re(c_re), .i_raddr(c_raddr), .o_rdata(c_rdata)
    );

    pect_ram #(.WIDTH(IW), .DEPTH(pect_pkg::MAX_CORNERS)) u_link (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_re(l_re), .i_raddr(l_raddr), .o_rdata(l_rdata)
    );

    pect_ram #(.WIDTH(TW), .DEPTH(pect_pkg::MAX_CORNERS)) u_tri (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_re(t_re), .i_raddr(t_raddr), .o_rdata(t_rdata)
    );

    assign prod  = ma * mb;
    assign xprod = XW'(r_pa) - XW'(r_pb);
    assign c_proj = pect_pkg::proj(c_rdata, r_plane);
    assign ax = pect_pkg::mag(r_nx);
    assign ay = pect_pkg::mag(r_ny);
    assign az = pect_pkg::mag(r_nz);

    always_comb begin
        in_c.x = i_in_word.corner_x;
        in_c.y = i_in_word.corner_y;
        in_c.z = i_in_word.corner_z;
        // edge endpoints for the current containment side
        unique case (r_sd)
            2'd0: begin
                sa = r_pp;
                sb = r_pc;
            end
            2'd1: begin
                sa = r_pc;
                sb = r_pn;
            end
            default: begin
                sa = r_pn;
                sb = r_pp;
            end
        endcase
        neg_now   = xprod[XW-1];
        pos_now   = !xprod[XW-1] && (xprod != '0);
        ear       = r_ccw ? !neg_now : !pos_now;
        last_link = ({1'b0, r_i} == r_count - CW'(1));
        last_out  = (r_k == r_ntri - IW'(1));
    end

    always_comb begin
        n_st = r_st; n_count = r_count; n_rem = r_rem; n_noprog = r_noprog;
        n_ovf = r_ovf; n_closing = r_closing; n_wrapped = r_wrapped;
        n_first = r_first; n_last = r_last; n_a = r_a; n_b = r_b; n_ph = r_ph;
        n_nx = r_nx; n_ny = r_ny; n_nz = r_nz; n_pa = r_pa; n_pb = r_pb;
        n_plane = r_plane; n_ccw = r_ccw; n_fan = r_fan; n_neg = r_neg; n_pos = r_pos;
        n_i = r_i; n_cur = r_cur; n_pv = r_pv; n_nv = r_nv; n_ntri = r_ntri;
        n_probe = r_probe; n_fb = r_fb; n_k = r_k; n_pp = r_pp; n_pc = r_pc;
        n_pn = r_pn; n_pq = r_pq; n_sd = r_sd; n_ovalid = r_ovalid; n_oword = r_oword;
        c_we = 1'b0; c_waddr = r_count[IW-1:0]; c_wdata = in_c; c_re = 1'b0; c_raddr = r_cur;
        l_we = 1'b0; l_waddr = r_i; l_wdata = '0; l_re = 1'b0; l_raddr = r_cur;
        t_we = 1'b0; t_waddr = r_ntri; t_wdata = '0; t_re = 1'b0; t_raddr = r_k;
        ma = '0; mb = '0;

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_st)
            S_IN: begin
                if (i_in_valid) begin
                    n_closing = i_in_word.last_corner;
                    n_wrapped = 1'b0;
                    n_ph      = '0;
                    if (r_count < CW'(pect_pkg::MAX_CORNERS)) begin
                        c_we    = 1'b1;
                        n_count = r_count + CW'(1);
                        n_a     = r_last;
                        n_b     = in_c;
                        n_last  = in_c;
                        if (r_count == '0) begin
                            n_first = in_c;
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if ((r_count < CW'(pect_pkg::MAX_CORNERS)) && (r_count != '0)) begin
                        n_st = S_TERM;
                    end else if (i_in_word.last_corner) begin
                        n_st = S_WRAP;
                    end
                end
            end
            S_WRAP: begin
                // close the ring: last stored corner back to the first
                n_a       = r_last;
                n_b       = r_first;
                n_wrapped = 1'b1;
                n_ph      = '0;
                n_st      = S_TERM;
            end
            S_TERM: begin
                unique case (r_ph)
                    3'd0: begin
                        ma = pect_pkg::sub_w(r_a.y, r_b.y);
                        mb = pect_pkg::add_w(r_a.z, r_b.z);
                    end
                    3'd2: begin
                        ma = pect_pkg::sub_w(r_a.z, r_b.z);
                        mb = pect_pkg::add_w(r_a.x, r_b.x);
                    end
                    default: begin
                        ma = pect_pkg::sub_w(r_a.x, r_b.x);
                        mb = pect_pkg::add_w(r_a.y, r_b.y);
                    end
                endcase
                if (!r_ph[0]) begin
                    n_pa = prod;
                end else if (r_ph == 3'd1) begin
                    n_nx = r_nx + AW'(r_pa);
                end else if (r_ph == 3'd3) begin
                    n_ny = r_ny + AW'(r_pa);
                end else begin
                    n_nz = r_nz + AW'(r_pa);
                end
                n_ph = r_ph + 3'd1;
                if (r_ph == 3'd5) begin
                    if (!r_closing) begin
                        n_st = S_IN;
                    end else if (!r_wrapped) begin
                        n_st = S_WRAP;
                    end else begin
                        n_st = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                if (r_count < CW'(3)) begin
                    n_count = '0; n_ovf = 1'b0; n_closing = 1'b0;
                    n_nx = '0; n_ny = '0; n_nz = '0;
                    n_st = S_IN;
                end else begin
                    // the Newell component of the dominant axis is the
                    // doubled signed area in the kept plane
                    if (ax >= ay && ax >= az) begin
                        n_plane = pect_pkg::PL_YZ;
                        n_ccw   = !r_nx[AW-1];
                    end else if (ay >= ax && ay >= az) begin
                        n_plane = pect_pkg::PL_ZX;
                        n_ccw   = !r_ny[AW-1];
                    end else begin
                        n_plane = pect_pkg::PL_XY;
                        n_ccw   = !r_nz[AW-1];
                    end
                    n_i  = '0;
                    n_st = S_LINK;
                end
            end
            S_LINK: begin
                l_we    = 1'b1;
                l_waddr = r_i;
                l_wdata = last_link ? '0 : r_i + IW'(1);
                n_i     = r_i + IW'(1);
                if (last_link) begin
                    n_cur    = '0;
                    n_pv     = r_i;
                    n_rem    = r_count;
                    n_noprog = '0;
                    n_ntri   = '0;
                    n_fan    = 1'b0;
                    n_st     = S_STEP;
                end
            end
            S_STEP: begin
                l_re    = 1'b1;
                l_raddr = r_cur;
                n_st    = (r_rem > CW'(3)) ? S_LD : S_FIN;
            end
            S_LD: begin
                n_nv    = l_rdata;
                c_re    = 1'b1;
                c_raddr = r_pv;
                n_st    = S_CP;
            end
            S_CP: begin
                n_pp    = c_proj;
                c_re    = 1'b1;
                c_raddr = r_cur;
                n_st    = S_CC;
            end
            S_CC: begin
                n_pc    = c_proj;
                c_re    = 1'b1;
                c_raddr = r_nv;
                n_st    = S_CN;
            end
            S_CN: begin
                n_pn = c_proj;
                n_ph = '0;
                n_st = S_TURN;
            end
            S_TURN: begin
                if (r_ph == 3'd0) begin
                    ma = pect_pkg::sub_w(r_pc.u, r_pp.u);
                    mb = pect_pkg::sub_w(r_pn.v, r_pc.v);
                end else begin
                    ma = pect_pkg::sub_w(r_pc.v, r_pp.v);
                    mb = pect_pkg::sub_w(r_pn.u, r_pc.u);
                end
                n_ph = r_ph + 3'd1;
                if (r_ph == 3'd0) begin
                    n_pa = prod;
                end else if (r_ph == 3'd1) begin
                    n_pb = prod;
                end else if (ear) begin
                    l_re    = 1'b1;
                    l_raddr = r_nv;
                    n_st    = S_PL;
                end else begin
                    n_st = S_NOEAR;
                end
            end
            S_PL: begin
                n_probe = l_rdata;
                if (l_rdata == r_pv) begin
                    n_st = S_CLIP;
                end else if (l_rdata == r_cur) begin
                    l_re    = 1'b1;
                    l_raddr = l_rdata;
                end else begin
                    c_re    = 1'b1;
                    c_raddr = l_rdata;
                    n_st    = S_PQ;
                end
            end
            S_PQ: begin
                n_pq  = c_proj;
                n_sd  = '0;
                n_ph  = '0;
                n_neg = 1'b0;
                n_pos = 1'b0;
                n_st  = S_SIDE;
            end
            S_SIDE: begin
                if (r_ph == 3'd0) begin
                    ma = pect_pkg::sub_w(r_pq.u, sb.u);
                    mb = pect_pkg::sub_w(sa.v, sb.v);
                end else begin
                    ma = pect_pkg::sub_w(sa.u, sb.u);
                    mb = pect_pkg::sub_w(r_pq.v, sb.v);
                end
                n_ph = r_ph + 3'd1;
                if (r_ph == 3'd0) begin
                    n_pa = prod;
                end else if (r_ph == 3'd1) begin
                    n_pb = prod;
                end else begin
                    n_neg = r_neg || neg_now;
                    n_pos = r_pos || pos_now;
                    n_ph  = '0;
                    n_sd  = r_sd + 2'd1;
                    if (r_sd == 2'd2) begin
                        // on the edge counts as inside
                        if (!(n_neg && n_pos)) begin
                            n_st = S_NOEAR;
                        end else begin
                            l_re    = 1'b1;
                            l_raddr = r_probe;
                            n_st    = S_PL;
                        end
                    end
                end
            end
            S_NOEAR: begin
                n_pv     = r_cur;
                n_cur    = r_nv;
                n_noprog = r_noprog + CW'(1);
                if (n_noprog >= r_rem) begin
                    n_fan = 1'b1;
                    n_st  = S_FAN0;
                end else begin
                    n_st = S_STEP;
                end
            end
            S_CLIP: begin
                l_we     = 1'b1;
                l_waddr  = r_pv;
                l_wdata  = r_nv;
                t_we     = 1'b1;
                t_wdata  = '{first: r_pv, second: r_cur, third: r_nv};
                n_ntri   = r_ntri + IW'(1);
                n_rem    = r_rem - CW'(1);
                n_noprog = '0;
                n_cur    = r_nv;
                n_st     = S_STEP;
            end
            S_FIN: begin
                t_we    = 1'b1;
                t_wdata = '{first: r_cur, second: l_rdata, third: r_pv};
                n_ntri  = r_ntri + IW'(1);
                n_k     = '0;
                n_st    = S_ORD;
            end
            S_FAN0: begin
                l_re    = 1'b1;
                l_raddr = r_cur;
                n_st    = S_FAN1;
            end
            S_FAN1: begin
                n_fb    = l_rdata;
                l_re    = 1'b1;
                l_raddr = l_rdata;
                n_st    = S_FAN2;
            end
            S_FAN2: begin
                if (l_rdata == r_cur) begin
                    n_k  = '0;
                    n_st = S_ORD;
                end else begin
                    t_we    = 1'b1;
                    t_wdata = '{first: r_cur, second: r_fb, third: l_rdata};
                    n_ntri  = r_ntri + IW'(1);
                    n_fb    = l_rdata;
                    l_re    = 1'b1;
                    l_raddr = l_rdata;
                end
            end
            S_ORD: begin
                if (!r_ovalid) begin
                    t_re = 1'b1;
                    n_st = S_OLD;
                end
            end
            S_OLD: begin
                n_ovalid = 1'b1;
                n_oword.tri_first       = t_rdata.first;
                n_oword.tri_second      = t_rdata.second;
                n_oword.tri_third       = t_rdata.third;
                n_oword.last_triangle   = last_out;
                n_oword.fan_fallback    = r_fan;
                n_oword.corners_dropped = r_ovf;
                n_k = r_k + IW'(1);
                if (last_out) begin
                    n_count = '0; n_ovf = 1'b0; n_closing = 1'b0;
                    n_nx = '0; n_ny = '0; n_nz = '0;
                    n_st = S_IN;
                end else begin
                    n_st = S_ORD;
                end
            end
            default: begin
                n_st = S_IN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IN;
            r_count <= '0;
            r_ovf <= 1'b0;
            r_closing <= 1'b0;
            r_wrapped <= 1'b0;
            r_nx <= '0;
            r_ny <= '0;
            r_nz <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            r_count <= n_count;
            r_ovf <= n_ovf;
            r_closing <= n_closing;
            r_wrapped <= n_wrapped;
            r_nx <= n_nx;
            r_ny <= n_ny;
            r_nz <= n_nz;
            r_ovalid <= n_ovalid;
        end
        r_rem <= n_rem; r_noprog <= n_noprog; r_first <= n_first; r_last <= n_last;
        r_a <= n_a; r_b <= n_b; r_ph <= n_ph; r_pa <= n_pa; r_pb <= n_pb;
        r_plane <= n_plane; r_ccw <= n_ccw; r_fan <= n_fan; r_neg <= n_neg;
        r_pos <= n_pos; r_i <= n_i; r_cur <= n_cur; r_pv <= n_pv; r_nv <= n_nv;
        r_ntri <= n_ntri; r_probe <= n_probe; r_fb <= n_fb; r_k <= n_k;
        r_pp <= n_pp; r_pc <= n_pc; r_pn <= n_pn; r_pq <= n_pq; r_sd <= n_sd;
        r_oword <= n_oword;
    end

    assign o_in_stall  = (r_st != S_IN);
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;

endmodule

// File: hdl/pect_checker.sv
// ----------------------------------------------------------------------------
// pect_checker
// Port-level checks on the triangulator, bound to the top level.
// ----------------------------------------------------------------------------
module pect_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input pect_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input pect_pkg::t_out_word o_out_word
);

    // hold a stalled word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    // a triangle never repeats a corner
    a_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.tri_first != o_out_word.tri_second) &&
                        (o_out_word.tri_second != o_out_word.tri_third) &&
                        (o_out_word.tri_first != o_out_word.tri_third))
        else $error("triangle with repeated corner");

    // come out of reset ready for corners with nothing pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall && !o_out_valid)
        else $error("not idle after reset");

    // a closing corner always stalls further corners
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_word.last_corner |=> o_in_stall)
        else $error("last corner did not start triangulation");

endmodule

bind polygon_ear_clip_triangulator pect_checker u_pect_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in_valid),
    .o_in_stall(o_in_stall),
    .i_in_word(i_in_word),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_word(o_out_word)
);
